// File: hw/rtl/remote_command_pulse_encoder_assert.svh
// Assertion macros for the remote command pulse encoder.
`ifndef REMOTE_COMMAND_PULSE_ENCODER_ASSERT_SVH
`define REMOTE_COMMAND_PULSE_ENCODER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define RCPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define RCPE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/rcpe_pkg.sv
`timescale 1ns / 1ps
package rcpe_pkg;

  localparam int unsigned PAIR_COUNT = 42;
  localparam int unsigned DATA_BITS  = 40;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned TICK_W     = 12;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PAIR_COUNT - 1);

  localparam logic [1:0] CMD_SHOCK   = 2'd0;
  localparam logic [1:0] CMD_VIBRATE = 2'd1;
  localparam logic [1:0] CMD_SOUND   = 2'd2;
  localparam logic [1:0] CMD_INVALID = 2'd3;

  localparam logic [1:0] KIND_SHOCK   = 2'd1;
  localparam logic [1:0] KIND_VIBRATE = 2'd2;
  localparam logic [1:0] KIND_SOUND   = 2'd3;

  localparam logic [7:0] FRAME_HEAD    = 8'h04;
  localparam logic [1:0] CHANNEL_RESET = 2'd1;

  // floor(p * 15 / 100) == (p * 78645) >> 19 for every 8-bit p
  localparam logic [16:0] SCALE_RECIP = 17'd78645;
  localparam int unsigned SCALE_SHIFT = 19;

  localparam logic [TICK_W-1:0] PRE_HIGH  = 12'd1900;
  localparam logic [TICK_W-1:0] PRE_LOW   = 12'd4000;
  localparam logic [TICK_W-1:0] ONE_HIGH  = 12'd900;
  localparam logic [TICK_W-1:0] ONE_LOW   = 12'd300;
  localparam logic [TICK_W-1:0] ZERO_HIGH = 12'd300;
  localparam logic [TICK_W-1:0] ZERO_LOW  = 12'd900;
  localparam logic [TICK_W-1:0] POST_HIGH = 12'd200;
  localparam logic [TICK_W-1:0] POST_LOW  = 12'd2200;

  typedef struct packed {
    logic [15:0] device_id;
    logic [1:0]  command;
    logic [7:0]  strength_percent;
  } cmd_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              bad_command;
    logic              final_pulse;
  } pulse_res_t;

  typedef struct packed {
    logic                 bad;
    logic [DATA_BITS-1:0] word;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: hw/rtl/remote_command_pulse_encoder.sv
// A taken request is written into the queue and popped into the back end's active register;
// pulse results and strobes are registered from there. A frame is 42 pulse pairs on
// consecutive strobes, an invalid command one. A two-entry queue lets the next request be
// taken while a frame is still being sent; busy is high only while both entries are waiting.
// Reset: channel select returns to 1, the queue empties and no result is in flight.
`timescale 1ns / 1ps
`include "remote_command_pulse_encoder_assert.svh"
module remote_command_pulse_encoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  rcpe_pkg::cmd_req_t   req_i,
  output logic                 strobe_o,
  output rcpe_pkg::pulse_res_t res_o
);

  rcpe_pkg::frame_t      front_frame;
  rcpe_pkg::frame_t      head_frame;
  rcpe_pkg::queue_stat_t q_stat;
  logic                  push;
  logic                  pop;
  logic                  back_active;
  logic                  take;

  assign busy = q_stat.full;
  assign take = start && !busy;

  rcpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .req_i       (req_i),
    .push_o      (push),
    .frame_o     (front_frame)
  );

  rcpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (front_frame),
    .pop_i   (pop),
    .frame_o (head_frame),
    .stat_o  (q_stat)
  );

  rcpe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (head_frame),
    .stat_i   (q_stat),
    .pop_o    (pop),
    .active_o (back_active),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

  `RCPE_ASSERT(a_frame_contiguous, strobe_o && !res_o.final_pulse |=> strobe_o, "frame broke off")
  `RCPE_ASSERT(a_bad_is_final, strobe_o && res_o.bad_command |-> res_o.final_pulse, "bad not final")
  `RCPE_ASSERT(a_take_held, take |=> !q_stat.empty || back_active, "request lost")

endmodule

// File: hw/rtl/rcpe_front.sv
`timescale 1ns / 1ps
module rcpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              take_i,
  input  rcpe_pkg::cmd_req_t req_i,
  output logic              push_o,
  output rcpe_pkg::frame_t  frame_o
);

  logic [1:0]  channel_q;
  logic [24:0] prod;
  logic [5:0]  quot;
  logic [3:0]  level;
  logic [1:0]  kind;
  logic [7:0]  low_byte;
  logic [7:0]  sum;
  logic        bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= rcpe_pkg::CHANNEL_RESET;
    end else if (cfg_we_i) begin
      channel_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    prod = 25'(req_i.strength_percent) * 25'(rcpe_pkg::SCALE_RECIP);
    quot = prod[24:rcpe_pkg::SCALE_SHIFT];
    bad  = 1'b0;
    case (req_i.command)
      rcpe_pkg::CMD_SHOCK:   kind = rcpe_pkg::KIND_SHOCK;
      rcpe_pkg::CMD_VIBRATE: kind = rcpe_pkg::KIND_VIBRATE;
      rcpe_pkg::CMD_SOUND:   kind = rcpe_pkg::KIND_SOUND;
      default: begin
        kind = rcpe_pkg::KIND_SHOCK;
        bad  = 1'b1;
      end
    endcase
    if (req_i.strength_percent == 8'd0 || kind == rcpe_pkg::KIND_SOUND) begin
      level = 4'd0;
    end else if (quot == 6'd0) begin
      level = 4'd1;
    end else begin
      level = quot[3:0];
    end
    low_byte = {kind, channel_q, level};
    sum = rcpe_pkg::FRAME_HEAD + req_i.device_id[15:8] + req_i.device_id[7:0] + low_byte;
  end

  assign push_o        = take_i;
  assign frame_o.bad   = bad;
  assign frame_o.word  = {rcpe_pkg::FRAME_HEAD, req_i.device_id, low_byte, sum};

endmodule

// File: hw/rtl/rcpe_queue.sv
`timescale 1ns / 1ps
module rcpe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rcpe_pkg::frame_t      frame_i,
  input  logic                  pop_i,
  output rcpe_pkg::frame_t      frame_o,
  output rcpe_pkg::queue_stat_t stat_o
);

  rcpe_pkg::frame_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  always_comb begin
    stat_o.full  = (count_q == 2'd2);
    stat_o.empty = (count_q == 2'd0);
    do_push  = push_i && !stat_o.full;
    do_pop   = pop_i && !stat_o.empty;
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  assign frame_o = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/rcpe_back.sv
`timescale 1ns / 1ps
module rcpe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcpe_pkg::frame_t      frame_i,
  input  rcpe_pkg::queue_stat_t stat_i,
  output logic                  pop_o,
  output logic                  active_o,
  output logic                  strobe_o,
  output rcpe_pkg::pulse_res_t  res_o
);

  logic                           active_q, active_d;
  logic                           bad_q, bad_d;
  logic [rcpe_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [rcpe_pkg::DATA_BITS-1:0] word_q, word_d;
  logic                           strobe_q;
  rcpe_pkg::pulse_res_t           res_q, res_d;
  logic                           last;

  always_comb begin
    last  = active_q && (bad_q || cnt_q == rcpe_pkg::LAST_IDX);
    pop_o = (!active_q || last) && !stat_i.empty;

    active_d = active_q;
    bad_d    = bad_q;
    cnt_d    = cnt_q;
    word_d   = word_q;
    if (pop_o) begin
      active_d = 1'b1;
      bad_d    = frame_i.bad;
      cnt_d    = '0;
      word_d   = frame_i.word;
    end else if (last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q != '0) begin
        word_d = {word_q[rcpe_pkg::DATA_BITS-2:0], 1'b0};
      end
    end

    res_d.bad_command = bad_q;
    res_d.final_pulse = last;
    if (bad_q) begin
      res_d.high_ticks = '0;
      res_d.low_ticks  = '0;
    end else if (cnt_q == '0) begin
      res_d.high_ticks = rcpe_pkg::PRE_HIGH;
      res_d.low_ticks  = rcpe_pkg::PRE_LOW;
    end else if (cnt_q == rcpe_pkg::LAST_IDX) begin
      res_d.high_ticks = rcpe_pkg::POST_HIGH;
      res_d.low_ticks  = rcpe_pkg::POST_LOW;
    end else if (word_q[rcpe_pkg::DATA_BITS-1]) begin
      res_d.high_ticks = rcpe_pkg::ONE_HIGH;
      res_d.low_ticks  = rcpe_pkg::ONE_LOW;
    end else begin
      res_d.high_ticks = rcpe_pkg::ZERO_HIGH;
      res_d.low_ticks  = rcpe_pkg::ZERO_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      strobe_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q  <= bad_d;
    cnt_q  <= cnt_d;
    word_q <= word_d;
    res_q  <= res_d;
  end

  assign active_o = active_q;
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule
